/* hdl/bdlp_pkg.sv */
// Package for the button debounce and long-press block.
// Holds the shared constants, register indexes and the state and event structs.
// No dependencies.
package bdlp_pkg;

	localparam int unsigned COUNTER_BITS_DEF = 16;
	localparam int unsigned TOTAL_W = 16;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned HIST_W = 8;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LEVEL = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME = 1'b1;

	localparam logic [TIME_W-1:0] HOLD_TIME_RST = 32'd1500;

	// History patterns.
	localparam logic [HIST_W-1:0] PATTERN_MASK = 8'b1100_0111;
	localparam logic [HIST_W-1:0] PRESS_PATTERN = 8'b0000_0111;
	localparam logic [HIST_W-1:0] RELEASE_PATTERN = 8'b1100_0000;
	localparam logic [HIST_W-1:0] ALL_ONES = 8'b1111_1111;
	localparam logic [HIST_W-1:0] ALL_ZEROS = 8'b0000_0000;

	typedef struct packed {
		logic [HIST_W-1:0] history;
		logic [TIME_W-1:0] press_stamp;
		logic              lockout;
		logic              short_flag;
		logic              long_flag;
	} dbn_state_t;

	typedef struct packed {
		logic pressed;
		logic released;
		logic long_press;
	} dbn_event_t;

endpackage

/* hdl/bdlp_channels.sv */
// Channel interfaces for the button debounce block: samples in, results out.
// Depends on bdlp_pkg for field widths.
interface bdlp_sample_if;
	logic                        valid;
	logic                        ready;
	logic                        raw_level;
	logic [bdlp_pkg::TIME_W-1:0] now_ms;
	logic                        clear_latches;

	modport source (output valid, raw_level, now_ms, clear_latches, input ready);
	modport sink (input valid, raw_level, now_ms, clear_latches, output ready);
endinterface

interface bdlp_result_if;
	logic                         valid;
	logic                         ready;
	logic                         pressed_event;
	logic                         released_event;
	logic                         long_press_event;
	logic                         short_latched;
	logic                         long_latched;
	logic                         locked_out;
	logic [bdlp_pkg::TOTAL_W-1:0] press_total;
	logic [bdlp_pkg::TOTAL_W-1:0] release_total;
	logic [bdlp_pkg::TOTAL_W-1:0] long_press_total;

	modport source (output valid, pressed_event, released_event, long_press_event,
		short_latched, long_latched, locked_out, press_total, release_total,
		long_press_total, input ready);
	modport sink (input valid, pressed_event, released_event, long_press_event,
		short_latched, long_latched, locked_out, press_total, release_total,
		long_press_total, output ready);
endinterface

/* hdl/bdlp_step.sv */
// Next-state logic for one button sample: shift, release, press and long-press checks.
// Depends on bdlp_pkg.
module bdlp_step (
	input  bdlp_pkg::dbn_state_t          cur,
	input  logic                          raw_level,
	input  logic [bdlp_pkg::TIME_W-1:0]   now_ms,
	input  logic                          clear_latches,
	input  logic                          active_level,
	input  logic [bdlp_pkg::TIME_W-1:0]   hold_time,
	output bdlp_pkg::dbn_state_t          nxt,
	output bdlp_pkg::dbn_event_t          evt
);
	import bdlp_pkg::*;

	logic [HIST_W-1:0] shifted;
	logic [HIST_W-1:0] after_rel;
	logic [HIST_W-1:0] after_prs;
	logic [TIME_W-1:0] stamp;
	logic [TIME_W-1:0] elapsed;
	logic              rel;
	logic              prs;
	logic              lng;

	assign shifted = {cur.history[HIST_W-2:0], raw_level == active_level};
	assign rel = !cur.lockout && ((shifted & PATTERN_MASK) == RELEASE_PATTERN);
	assign after_rel = rel ? ALL_ZEROS : shifted;
	assign prs = !cur.lockout && ((after_rel & PATTERN_MASK) == PRESS_PATTERN);
	assign after_prs = prs ? ALL_ONES : after_rel;
	assign stamp = prs ? now_ms : cur.press_stamp;
	// Wrapping subtraction gives the time held even across a timer rollover.
	assign elapsed = now_ms - stamp;
	assign lng = !cur.lockout && (after_prs == ALL_ONES) && (elapsed >= hold_time);

	always_comb begin
		nxt.history = after_prs;
		nxt.press_stamp = stamp;
		nxt.short_flag = (cur.short_flag && !clear_latches) || rel;
		nxt.long_flag = (cur.long_flag && !clear_latches) || lng;
		if (cur.lockout) begin
			nxt.lockout = (shifted != ALL_ZEROS);
		end else begin
			nxt.lockout = lng;
		end
		evt.pressed = prs;
		evt.released = rel;
		evt.long_press = lng;
	end

endmodule

/* hdl/button_debounce_long_press.sv */
// Top level of the button debounce block with long-press detection.
// Depends on bdlp_pkg, bdlp_channels (interfaces) and bdlp_step.
//
// Usage: each transfer on the sample channel carries one raw pin level, the
// current free-running millisecond time and a request to clear the short and
// long latches. Each sample yields exactly one transfer on the result channel,
// holding the events seen on that sample, the latched flags, the lockout state
// and the press, release and long-press totals after the sample.
//
// Flow: a sample is captured into an input register; when it moves on, the
// debounce logic updates the state and loads the result register, which then
// offers the result. Throughput is one sample per cycle while the receiver
// takes each result: the input register moves on whenever the result register
// is empty or being emptied. While a result waits, the input register still
// takes one more sample. When the receiver stalls, the result register holds
// and the input register fills; once both are full the sample ready drops
// until a result is taken.
//
// Reset clears the debounce history, press time stamp, latches, lockout and
// totals, empties both registers, sets the active level to low and the hold
// time to 1500 ms. Configuration writes are expected only while idle.
module button_debounce_long_press #(
	parameter int unsigned COUNTER_BITS = bdlp_pkg::COUNTER_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bdlp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bdlp_pkg::CFG_DATA_W-1:0]   cfg_data,
	bdlp_sample_if.sink                       sample,
	bdlp_result_if.source                     result
);
	import bdlp_pkg::*;

	// Configuration registers.
	logic              active_level_q;
	logic [TIME_W-1:0] hold_time_q;

	// Input register.
	logic              valid_s1;
	logic              raw_level_s1;
	logic [TIME_W-1:0] now_ms_s1;
	logic              clear_s1;

	// Debounce state and event counters.
	dbn_state_t              state_q;
	dbn_state_t              state_nxt;
	dbn_event_t              evt;
	logic [COUNTER_BITS-1:0] press_cnt_q;
	logic [COUNTER_BITS-1:0] release_cnt_q;
	logic [COUNTER_BITS-1:0] long_cnt_q;
	logic [COUNTER_BITS-1:0] press_cnt_nxt;
	logic [COUNTER_BITS-1:0] release_cnt_nxt;
	logic [COUNTER_BITS-1:0] long_cnt_nxt;

	// Result register.
	logic out_valid_q;
	logic advance;

	// The input register hands its sample on when the result register is free
	// or is being read in this cycle.
	assign advance = valid_s1 && (!out_valid_q || result.ready);
	assign sample.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_level_q <= 1'b0;
			hold_time_q <= HOLD_TIME_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ACTIVE_LEVEL: active_level_q <= cfg_data[0];
				CFG_HOLD_TIME: hold_time_q <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			raw_level_s1 <= sample.raw_level;
			now_ms_s1 <= sample.now_ms;
			clear_s1 <= sample.clear_latches;
		end
	end

	bdlp_step u_step (
		.cur           (state_q),
		.raw_level     (raw_level_s1),
		.now_ms        (now_ms_s1),
		.clear_latches (clear_s1),
		.active_level  (active_level_q),
		.hold_time     (hold_time_q),
		.nxt           (state_nxt),
		.evt           (evt)
	);

	// Counters wrap at their own width.
	assign press_cnt_nxt = press_cnt_q + COUNTER_BITS'(evt.pressed);
	assign release_cnt_nxt = release_cnt_q + COUNTER_BITS'(evt.released);
	assign long_cnt_nxt = long_cnt_q + COUNTER_BITS'(evt.long_press);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			press_cnt_q <= '0;
			release_cnt_q <= '0;
			long_cnt_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
			press_cnt_q <= press_cnt_nxt;
			release_cnt_q <= release_cnt_nxt;
			long_cnt_q <= long_cnt_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload; totals show the low bits of each counter, zero-extended
	// when the counters are narrower than the result field.
	always_ff @(posedge clk) begin
		if (advance) begin
			result.pressed_event <= evt.pressed;
			result.released_event <= evt.released;
			result.long_press_event <= evt.long_press;
			result.short_latched <= state_nxt.short_flag;
			result.long_latched <= state_nxt.long_flag;
			result.locked_out <= state_nxt.lockout;
			result.press_total <= TOTAL_W'(press_cnt_nxt);
			result.release_total <= TOTAL_W'(release_cnt_nxt);
			result.long_press_total <= TOTAL_W'(long_cnt_nxt);
		end
	end

	assign result.valid = out_valid_q;

endmodule
